// ===== rtl/core/huffman_code_bit_packer_assert.svh =====
// Assertion macros for the Huffman code bit packer.
// Used by modules that sample on aclk with the active-low aresetn.
`ifndef HUFFMAN_CODE_BIT_PACKER_ASSERT_SVH
`define HUFFMAN_CODE_BIT_PACKER_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define HCBP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("hcbp assertion failed");

// The consequent holds in the cycle after the antecedent.
`define HCBP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("hcbp assertion failed");

`endif

// ===== rtl/core/hcbp_pkg.sv =====
// Shared constants, types and the control program of the Huffman code bit packer.
// No dependencies; used by hcbp_code_store, huffman_code_bit_packer and the testbench.
package hcbp_pkg;

    localparam int MAX_CODE_LEN = 32;
    localparam int BYTE_BITS    = 8;
    localparam int RAW_MAX      = 32;
    localparam int TABLE_DEPTH  = 256;
    localparam int TABLE_AW     = $clog2(TABLE_DEPTH);
    localparam int LEN_W        = 6;
    localparam int CODE_W       = 32;
    localparam int ACC_W        = CODE_W + BYTE_BITS;

    localparam logic [LEN_W-1:0] LEN_LIMIT =
        LEN_W'((MAX_CODE_LEN < RAW_MAX) ? MAX_CODE_LEN : RAW_MAX);

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
    } code_entry_t;

    typedef logic [1:0] kind_t;
    localparam kind_t KIND_LOAD   = 2'd0;
    localparam kind_t KIND_ENCODE = 2'd1;
    localparam kind_t KIND_RAW    = 2'd2;
    localparam kind_t KIND_FLUSH  = 2'd3;

    typedef logic [3:0] step_t;
    localparam step_t ST_IDLE     = 4'd0;
    localparam step_t ST_DISPATCH = 4'd1;
    localparam step_t ST_LOADCHK  = 4'd2;
    localparam step_t ST_LOADWR   = 4'd3;
    localparam step_t ST_RAWCHK   = 4'd4;
    localparam step_t ST_RAWAPP   = 4'd5;
    localparam step_t ST_MEMAPP   = 4'd6;
    localparam step_t ST_EMITCHK  = 4'd7;
    localparam step_t ST_EMIT     = 4'd8;
    localparam step_t ST_ERROR    = 4'd9;
    localparam step_t ST_FLUSHCHK = 4'd10;
    localparam step_t ST_FLUSH    = 4'd11;

    typedef logic [2:0] op_t;
    localparam op_t OP_NONE       = 3'd0;
    localparam op_t OP_ACCEPT     = 3'd1;
    localparam op_t OP_WRITE      = 3'd2;
    localparam op_t OP_APPEND_RAW = 3'd3;
    localparam op_t OP_APPEND_MEM = 3'd4;
    localparam op_t OP_EMIT       = 3'd5;
    localparam op_t OP_ERROR      = 3'd6;
    localparam op_t OP_FLUSH      = 3'd7;

    typedef logic [2:0] cond_t;
    localparam cond_t C_NEXT   = 3'd0;
    localparam cond_t C_ALWAYS = 3'd1;
    localparam cond_t C_ACCEPT = 3'd2;
    localparam cond_t C_KIND   = 3'd3;
    localparam cond_t C_LENBAD = 3'd4;
    localparam cond_t C_NOMORE = 3'd5;
    localparam cond_t C_NOHELD = 3'd6;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        logic  needs_out;
        step_t target;
    } ucode_t;

    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t cw;
        unique case (step)
            ST_IDLE:     cw = '{OP_ACCEPT,     C_ACCEPT, 1'b0, ST_DISPATCH};
            ST_DISPATCH: cw = '{OP_NONE,       C_KIND,   1'b0, ST_IDLE};
            ST_LOADCHK:  cw = '{OP_NONE,       C_LENBAD, 1'b0, ST_ERROR};
            ST_LOADWR:   cw = '{OP_WRITE,      C_ALWAYS, 1'b0, ST_IDLE};
            ST_RAWCHK:   cw = '{OP_NONE,       C_LENBAD, 1'b0, ST_ERROR};
            ST_RAWAPP:   cw = '{OP_APPEND_RAW, C_ALWAYS, 1'b0, ST_EMITCHK};
            ST_MEMAPP:   cw = '{OP_APPEND_MEM, C_NEXT,   1'b0, ST_EMITCHK};
            ST_EMITCHK:  cw = '{OP_NONE,       C_NOMORE, 1'b0, ST_IDLE};
            ST_EMIT:     cw = '{OP_EMIT,       C_ALWAYS, 1'b1, ST_EMITCHK};
            ST_ERROR:    cw = '{OP_ERROR,      C_ALWAYS, 1'b1, ST_IDLE};
            ST_FLUSHCHK: cw = '{OP_NONE,       C_NOHELD, 1'b0, ST_IDLE};
            ST_FLUSH:    cw = '{OP_FLUSH,      C_ALWAYS, 1'b1, ST_IDLE};
            default:     cw = '{OP_NONE,       C_ALWAYS, 1'b0, ST_IDLE};
        endcase
        return cw;
    endfunction

endpackage

// ===== rtl/core/hcbp_code_store.sv =====
// Code table of the bit packer: 256 entries of code and length, registered read.
// Depends on hcbp_pkg for the entry type and address width.
module hcbp_code_store
    import hcbp_pkg::*;
(
    input  logic                aclk,
    input  logic                wr_en,
    input  logic [TABLE_AW-1:0] wr_addr,
    input  code_entry_t         wr_data,
    input  logic [TABLE_AW-1:0] rd_addr,
    output code_entry_t         rd_data
);

    code_entry_t mem [TABLE_DEPTH];
    code_entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/huffman_code_bit_packer.sv =====
// Channel  Dir  Ports        Words
// s_       in   tdata/tuser  load, encode, raw or flush command
// m_       out  tdata/tlast  packed byte, or a length error flagged in tuser
//
// Top level of the Huffman code bit packer: sequencer, bit accumulator, output register.
// Depends on hcbp_pkg, hcbp_code_store and huffman_code_bit_packer_assert.svh.
//
// A sequencer steps through a control program, one step per cycle unless it waits
// for input or output. Load writes the table, encode and raw append bits and send full
// bytes, flush sends held bits. An output word waits in the register while the next
// command is taken; a byte step holds while that register is full and not taken.
// Reset empties the accumulator; table entries are undefined until loaded.
module huffman_code_bit_packer
    import hcbp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // symbol[7:0], code_bits[39:8], code_len[45:40], zero
    input  logic [1:0]  s_tuser,  // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,  // out_byte[7:0]
    output logic        m_tlast,
    output logic        m_tuser   // len_error[0]
);

    step_t               step_reg, step_next;
    ucode_t              cw;
    kind_t               kind_reg;
    logic [TABLE_AW-1:0] sym_reg;
    logic [CODE_W-1:0]   bits_reg;
    logic [LEN_W-1:0]    len_reg;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic [LEN_W-1:0]    cnt_reg, cnt_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [7:0]          m_tdata_reg, m_tdata_next;
    logic                m_tlast_reg, m_tlast_next;
    logic                m_tuser_reg, m_tuser_next;
    code_entry_t         rd_entry;
    code_entry_t         wr_entry;
    logic                out_free, run, accept, len_bad;
    logic [CODE_W-1:0]   app_code, app_aligned;
    logic [LEN_W-1:0]    app_len;

    assign cw       = ucode_rom(step_reg);
    assign out_free = !m_tvalid_reg || m_tready;
    assign run      = !cw.needs_out || out_free;
    assign s_tready = (cw.op == OP_ACCEPT);
    assign accept   = s_tvalid && s_tready;
    assign len_bad  = (len_reg > LEN_LIMIT);
    assign wr_entry = '{len: len_reg, code: bits_reg};

    hcbp_code_store u_store (
        .aclk    (aclk),
        .wr_en   (cw.op == OP_WRITE),
        .wr_addr (sym_reg),
        .wr_data (wr_entry),
        .rd_addr (sym_reg),
        .rd_data (rd_entry)
    );

    always_comb begin
        step_next = step_reg + 4'd1;
        if (!run) begin
            step_next = step_reg;
        end else begin
            unique case (cw.cond)
                C_NEXT:   step_next = step_reg + 4'd1;
                C_ALWAYS: step_next = cw.target;
                C_ACCEPT: step_next = accept ? cw.target : step_reg;
                C_KIND: begin
                    unique case (kind_reg)
                        KIND_LOAD:   step_next = ST_LOADCHK;
                        KIND_ENCODE: step_next = ST_MEMAPP;
                        KIND_RAW:    step_next = ST_RAWCHK;
                        default:     step_next = ST_FLUSHCHK;
                    endcase
                end
                C_LENBAD: step_next = len_bad ? cw.target : step_reg + 4'd1;
                C_NOMORE: step_next = (cnt_reg <= 6'd8) ? cw.target : step_reg + 4'd1;
                C_NOHELD: step_next = (cnt_reg == '0) ? cw.target : step_reg + 4'd1;
                default:  step_next = ST_IDLE;
            endcase
        end
    end

    always_comb begin
        app_code    = (cw.op == OP_APPEND_MEM) ? rd_entry.code : bits_reg;
        app_len     = (cw.op == OP_APPEND_MEM) ? rd_entry.len : len_reg;
        app_aligned = app_code << (6'd32 - app_len);

        acc_next      = acc_reg;
        cnt_next      = cnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        m_tuser_next  = m_tuser_reg;

        if (run) begin
            case (cw.op)
                OP_APPEND_RAW, OP_APPEND_MEM: begin
                    acc_next = acc_reg | ({app_aligned, 8'b0} >> cnt_reg);
                    cnt_next = cnt_reg + app_len;
                end
                OP_EMIT: begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = acc_reg[ACC_W-1 -: BYTE_BITS];
                    m_tlast_next  = (cnt_reg <= 6'd16);
                    m_tuser_next  = 1'b0;
                    acc_next      = acc_reg << BYTE_BITS;
                    cnt_next      = cnt_reg - 6'd8;
                end
                OP_FLUSH: begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = acc_reg[ACC_W-1 -: BYTE_BITS];
                    m_tlast_next  = 1'b1;
                    m_tuser_next  = 1'b0;
                    acc_next      = '0;
                    cnt_next      = '0;
                end
                OP_ERROR: begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = '0;
                    m_tlast_next  = 1'b1;
                    m_tuser_next  = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg     <= ST_IDLE;
            acc_reg      <= '0;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            step_reg     <= step_next;
            acc_reg      <= acc_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
        m_tuser_reg <= m_tuser_next;
        if (accept) begin
            kind_reg <= s_tuser;
            sym_reg  <= s_tdata[7:0];
            bits_reg <= s_tdata[39:8];
            len_reg  <= s_tdata[45:40];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

`include "huffman_code_bit_packer_assert.svh"

    `HCBP_ASSERT_SAME(a_idle_partial, step_reg == ST_IDLE, cnt_reg <= 6'd8)
    `HCBP_ASSERT_NEXT(a_accept_dispatch, accept, step_reg == ST_DISPATCH)
    `HCBP_ASSERT_SAME(a_error_last, m_tvalid && m_tuser, m_tlast)
    `HCBP_ASSERT_SAME(a_more_bytes_busy, m_tvalid && !m_tlast, step_reg != ST_IDLE)

endmodule

// ===== tb/tb_huffman_code_bit_packer.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for huffman_code_bit_packer: streams load, encode, raw and
// flush words with random gaps on both sides and checks every packed byte against a
// local bit-packing predictor. Depends on hcbp_pkg and the block's RTL.
module tb_huffman_code_bit_packer
    import hcbp_pkg::*;
;

    localparam int MAX_LEN     = 32;
    localparam int RANDOM_CMDS = 235;
    localparam int HOLD_AFTER  = 40;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 50;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  symbol;
        logic [31:0] bits;
        logic [5:0]  len;
    } cmd_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       err;
    } byte_word_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;  // symbol[7:0], code_bits[39:8], code_len[45:40], zero
    logic [1:0]  s_tuser  = '0;  // kind[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;        // out_byte[7:0]
    logic        m_tlast;
    logic        m_tuser;        // len_error[0]

    cmd_t        cmd_q[$];
    byte_word_t  packed_q[$];
    cmd_t        tx_cur;
    int          tx_gap = 0;
    int          tx_calm = 0;
    int          rx_gap = 0;
    int          rx_calm = 0;
    int          bytes_seen = 0;
    int          hold_left = 0;
    logic        hold_done = 1'b0;
    int          fail_count = 0;

    logic [31:0] tbl_code [256];
    logic [5:0]  tbl_len  [256];
    logic [7:0]  acc_bits = '0;
    logic [3:0]  acc_held = '0;

    logic        is_loaded [256];
    logic [7:0]  loaded_list[$];

    huffman_code_bit_packer u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            calm = $urandom_range(8, 30);
            return 0;
        end
        return $urandom_range(0, 18);
    endfunction

    // Appends the packed bytes that one accepted command word produces.
    function automatic void pack_command(input cmd_t c);
        byte_word_t  words[$];
        logic [31:0] bits;
        int          len;
        int          i;
        bits = c.bits;
        len  = int'(c.len);
        if (c.kind == KIND_ENCODE) begin
            bits = tbl_code[c.symbol];
            len  = int'(tbl_len[c.symbol]);
        end
        if ((c.kind == KIND_LOAD || c.kind == KIND_RAW) && c.len > MAX_LEN) begin
            words.push_back('{data: 8'h00, last: 1'b0, err: 1'b1});
        end else if (c.kind == KIND_LOAD) begin
            tbl_code[c.symbol] = c.bits;
            tbl_len[c.symbol]  = c.len;
        end else if (c.kind == KIND_FLUSH) begin
            if (acc_held != 0)
                words.push_back('{data: 8'(acc_bits << (8 - acc_held)), last: 1'b0, err: 1'b0});
            acc_bits = '0;
            acc_held = '0;
        end else begin
            for (i = len; i > 0; i--) begin
                if (acc_held == 4'd8) begin
                    words.push_back('{data: acc_bits, last: 1'b0, err: 1'b0});
                    acc_bits = '0;
                    acc_held = '0;
                end
                acc_bits = {acc_bits[6:0], bits[i-1]};
                acc_held = acc_held + 4'd1;
            end
        end
        if (words.size() != 0)
            words[words.size()-1].last = 1'b1;
        foreach (words[k])
            packed_q.push_back(words[k]);
    endfunction

    function automatic void add_cmd(input kind_t kind, input logic [7:0] symbol,
                                    input logic [31:0] bits, input logic [5:0] len);
        cmd_q.push_back('{kind: kind, symbol: symbol, bits: bits, len: len});
        if (kind == KIND_LOAD && len <= MAX_LEN && !is_loaded[symbol]) begin
            is_loaded[symbol] = 1'b1;
            loaded_list.push_back(symbol);
        end
    endfunction

    function automatic logic [5:0] draw_len();
        if ($urandom_range(0, 19) == 0)
            return 6'($urandom_range(MAX_LEN + 1, 63));
        if ($urandom_range(0, 4) == 0)
            return 6'($urandom_range(0, MAX_LEN));
        return 6'($urandom_range(1, 12));
    endfunction

    always @(posedge aclk) begin
        int   g;
        cmd_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_gap   <= 0;
        end else begin
            g = tx_gap;
            if (s_tvalid && s_tready) begin
                pack_command(tx_cur);
                g = draw_wait(tx_calm);
            end else if (!s_tvalid && g > 0) begin
                g--;
            end
            if ((!s_tvalid || s_tready) && g == 0 && cmd_q.size() != 0) begin
                nxt = cmd_q.pop_front();
                tx_cur   <= nxt;
                s_tdata  <= {2'b00, nxt.len, nxt.bits, nxt.symbol};
                s_tuser  <= nxt.kind;
                s_tvalid <= 1'b1;
            end else if (!s_tvalid || s_tready) begin
                s_tvalid <= 1'b0;
            end
            tx_gap <= g;
        end
    end

    always @(posedge aclk) begin
        int         g;
        byte_word_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_gap   <= 0;
        end else begin
            g = rx_gap;
            if (m_tvalid && m_tready) begin
                bytes_seen <= bytes_seen + 1;
                if (packed_q.size() == 0) begin
                    $error("unexpected word: out_byte %0h last %0b len_error %0b",
                           m_tdata, m_tlast, m_tuser);
                    fail_count++;
                end else begin
                    want = packed_q.pop_front();
                    if (m_tdata !== want.data) begin
                        $error("out_byte: expected %0h, got %0h", want.data, m_tdata);
                        fail_count++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, m_tlast);
                        fail_count++;
                    end
                    if (m_tuser !== want.err) begin
                        $error("len_error: expected %0b, got %0b", want.err, m_tuser);
                        fail_count++;
                    end
                end
                g = draw_wait(rx_calm);
            end else if (g > 0) begin
                g--;
            end
            rx_gap   <= g;
            m_tready <= (g == 0) && (hold_left == 0);
        end
    end

    // One long output stall so that the block backs up and holds off its input.
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && bytes_seen >= HOLD_AFTER) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    initial begin
        int         n;
        int         pick;
        logic [7:0] sym;
        foreach (tbl_code[k]) begin
            tbl_code[k]  = '0;
            tbl_len[k]   = '0;
            is_loaded[k] = 1'b0;
        end

        add_cmd(KIND_FLUSH,  8'h00, 32'h0000_0000, 6'd0);
        add_cmd(KIND_RAW,    8'hFF, 32'hFFFF_FFFF, 6'd0);
        add_cmd(KIND_LOAD,   8'h00, 32'hFFFF_FFFF, 6'd32);
        add_cmd(KIND_LOAD,   8'hFF, 32'h0000_0000, 6'd1);
        add_cmd(KIND_LOAD,   8'hA5, 32'hFFFF_FFF6, 6'd5);
        add_cmd(KIND_LOAD,   8'h5A, 32'h1234_5678, 6'd0);
        add_cmd(KIND_LOAD,   8'h77, 32'hFFFF_FFFF, 6'd33);
        add_cmd(KIND_LOAD,   8'h77, 32'h0000_0001, 6'd63);
        add_cmd(KIND_RAW,    8'h00, 32'hFFFF_FFFF, 6'd63);
        add_cmd(KIND_ENCODE, 8'h00, 32'hFFFF_FFFF, 6'd63);
        add_cmd(KIND_FLUSH,  8'hFF, 32'hFFFF_FFFF, 6'd63);
        add_cmd(KIND_ENCODE, 8'hFF, 32'h0000_0000, 6'd0);
        add_cmd(KIND_ENCODE, 8'hA5, 32'h5555_5555, 6'd21);
        add_cmd(KIND_ENCODE, 8'h5A, 32'hAAAA_AAAA, 6'd42);
        add_cmd(KIND_RAW,    8'h3C, 32'h0000_00C3, 6'd8);
        add_cmd(KIND_RAW,    8'h00, 32'h1234_5678, 6'd32);
        add_cmd(KIND_RAW,    8'h00, 32'hFFFF_FFFF, 6'd40);
        add_cmd(KIND_RAW,    8'h00, 32'hDEAD_BEEF, 6'd31);
        add_cmd(KIND_FLUSH,  8'h00, 32'h0000_0000, 6'd0);
        add_cmd(KIND_RAW,    8'h00, 32'h0000_0001, 6'd1);
        add_cmd(KIND_FLUSH,  8'h00, 32'h0000_0000, 6'd0);
        add_cmd(KIND_FLUSH,  8'h00, 32'h0000_0000, 6'd0);
        add_cmd(KIND_LOAD,   8'hA5, 32'h0000_0003, 6'd2);
        add_cmd(KIND_ENCODE, 8'hA5, 32'h0000_0000, 6'd0);

        for (n = 0; n < RANDOM_CMDS; n++) begin
            pick = $urandom_range(0, 99);
            if (loaded_list.size() == 0 || pick < 12) begin
                add_cmd(KIND_LOAD, 8'($urandom_range(0, 255)), $urandom(), draw_len());
            end else if (pick < 72) begin
                sym = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
                add_cmd(KIND_ENCODE, sym, $urandom(), 6'($urandom_range(0, 63)));
            end else if (pick < 90) begin
                add_cmd(KIND_RAW, 8'($urandom_range(0, 255)), $urandom(), draw_len());
            end else begin
                add_cmd(KIND_FLUSH, 8'($urandom_range(0, 255)), $urandom(),
                        6'($urandom_range(0, 63)));
            end
        end
        add_cmd(KIND_FLUSH, 8'h00, 32'h0000_0000, 6'd0);

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        while (cmd_q.size() != 0 || s_tvalid || packed_q.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (fail_count == 0 && packed_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/hcbp_pkg.sv
rtl/core/hcbp_code_store.sv
rtl/core/huffman_code_bit_packer.sv
tb/tb_huffman_code_bit_packer.sv
